// ===== rtl/core/assert_macros.svh =====
// Assertion macros for the dot product core
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication property, checked on the rising clock edge outside reset
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication property, checked outside reset
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ===== rtl/core/sdp_pkg.sv =====
// ----------------------------------------------------------------------------
// sdp_pkg
// Shared types, constants and floating-point helpers of the dot product core.
// ----------------------------------------------------------------------------
package sdp_pkg;
    localparam int unsigned ACC_W = 32;
    localparam logic [3:0]  W_BIAS = 4'd8;
    localparam logic [7:0]  NIB_MASK = 8'h0F;
    localparam logic [31:0] CLAMP_MIN_RST = 32'hFF7F_FFFF;
    localparam logic [31:0] CLAMP_MAX_RST = 32'h7F7F_FFFF;

    typedef enum logic [0:0] {
        REG_CLAMP_MIN = 1'b0,
        REG_CLAMP_MAX = 1'b1
    } t_reg_idx;

    typedef enum logic [5:0] {
        ST_ACC  = 6'b000001,
        ST_CONV = 6'b000010,
        ST_MUL1 = 6'b000100,
        ST_MUL2 = 6'b001000,
        ST_CLMP = 6'b010000,
        ST_OUT  = 6'b100000
    } t_state;

    typedef struct packed {
        logic mac;
        logic conv;
        logic mul1;
        logic mul2;
        logic clamp;
        logic clr;
    } t_cmd;

    // IEEE less-than on binary32 patterns, NaN compares false
    function automatic logic f_lt(input logic [31:0] a, input logic [31:0] b);
        logic a_nan;
        logic b_nan;
        logic a_z;
        a_nan = (a[30:23] == 8'hFF) && (a[22:0] != 23'd0);
        b_nan = (b[30:23] == 8'hFF) && (b[22:0] != 23'd0);
        a_z = (a[30:0] == 31'd0) && (b[30:0] == 31'd0);
        if (a_nan || b_nan || a_z) begin
            f_lt = 1'b0;
        end else if (a[31] != b[31]) begin
            f_lt = a[31];
        end else if (a[31]) begin
            f_lt = a[30:0] > b[30:0];
        end else begin
            f_lt = a[30:0] < b[30:0];
        end
    endfunction
endpackage

// ===== rtl/core/sdp_if.sv =====
// ----------------------------------------------------------------------------
// sdp_if
// Valid/ready channel interfaces for input, result and configuration.
// ----------------------------------------------------------------------------
interface sdp_in_if;
    logic              valid;
    logic              ready;
    logic signed [7:0] act_value;
    logic [7:0]        weight_byte;
    logic              upper_half;
    logic signed [8:0] row_offset;
    logic [31:0]       act_scale_bits;
    logic [31:0]       weight_scale_bits;
    logic              run_end;
    modport source (output valid, act_value, weight_byte, upper_half, row_offset,
                    act_scale_bits, weight_scale_bits, run_end, input ready);
    modport sink (input valid, act_value, weight_byte, upper_half, row_offset,
                  act_scale_bits, weight_scale_bits, run_end, output ready);
endinterface

interface sdp_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] result_bits;
    modport source (output valid, result_bits, input ready);
    modport sink (input valid, result_bits, output ready);
endinterface

interface sdp_cfg_if;
    logic        valid;
    logic        ready;
    logic        index;
    logic [31:0] data;
    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

// ===== rtl/core/sdp_fmul.sv =====
// ----------------------------------------------------------------------------
// sdp_fmul
// Registered binary32 multiplier, round to nearest even, with subnormals.
// ----------------------------------------------------------------------------
module sdp_fmul
    import sdp_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_en,
    input  logic [31:0] i_a,
    input  logic [31:0] i_b,
    output logic [31:0] o_p
);
    logic [31:0] r_p;
    logic [31:0] n_p;

    always_comb begin
        logic        s;
        logic [7:0]  ea, eb;
        logic [23:0] ma, mb;
        logic        a_inf, b_inf, a_nan, b_nan, a_z, b_z;
        logic [47:0] prod;
        logic [5:0]  lz;
        logic signed [11:0] e;
        logic [47:0] norm;
        logic [7:0]  sh;
        logic [48:0] wide;
        logic        stk;
        logic [24:0] kept;
        logic        g;
        logic        rest;
        logic [24:0] rnd;
        logic [9:0]  eo;
        s = i_a[31] ^ i_b[31];
        ea = i_a[30:23];
        eb = i_b[30:23];
        ma = {(ea != 8'd0), i_a[22:0]};
        mb = {(eb != 8'd0), i_b[22:0]};
        a_nan = (ea == 8'hFF) && (i_a[22:0] != 23'd0);
        b_nan = (eb == 8'hFF) && (i_b[22:0] != 23'd0);
        a_inf = (ea == 8'hFF) && !a_nan;
        b_inf = (eb == 8'hFF) && !b_nan;
        a_z = (i_a[30:0] == 31'd0);
        b_z = (i_b[30:0] == 31'd0);
        prod = ma * mb;
        lz = 6'd0;
        for (int k = 47; k >= 0; k--) begin
            if (prod[k] && lz == 6'd0) begin
                lz = 6'(48 - k);
            end
        end
        // lz holds 1 + leading zero count, 0 when prod is zero
        e = 12'($signed({4'd0, ea}) + $signed({4'd0, eb}) - 12'sd127
            + ((ea == 8'd0) ? 12'sd1 : 12'sd0) + ((eb == 8'd0) ? 12'sd1 : 12'sd0)
            + 12'sd1 - $signed({6'd0, lz}) + 12'sd1);
        // value = prod * 2^(e_raw-... ); normalise leading one to bit 47
        norm = (lz == 6'd0) ? 48'd0 : (prod << (lz - 6'd1));
        if (e < 12'sd1) begin
            sh = (e < -12'sd30) ? 8'd31 : 8'(12'sd1 - e);
            e = 12'sd0;
        end else begin
            sh = 8'd0;
        end
        wide = {norm, 1'b0} >> sh;
        stk = 1'b0;
        for (int k = 0; k < 49; k++) begin
            if (k < 32 && 8'(k) < sh && norm[k]) begin
                stk = 1'b1;
            end
        end
        kept = {1'b0, wide[48:25]};
        g = wide[24];
        rest = (wide[23:0] != 24'd0) || stk;
        rnd = kept + {24'd0, (g && (rest || kept[0]))};
        eo = 10'(e);
        if (e == 12'sd0) begin
            eo = rnd[23] ? 10'd1 : 10'd0;
        end else if (rnd[24]) begin
            eo = 10'(e + 12'sd1);
            rnd = rnd >> 1;
        end
        if (a_nan || b_nan || (a_inf && b_z) || (b_inf && a_z)) begin
            n_p = 32'hFFC0_0000;
        end else if (a_inf || b_inf || (e > 12'sd254) || (eo > 10'd254)) begin
            n_p = {s, 8'hFF, 23'd0};
        end else if (a_z || b_z) begin
            n_p = {s, 31'd0};
        end else begin
            n_p = {s, eo[7:0], rnd[22:0]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_p <= n_p;
        end
    end

    assign o_p = r_p;
endmodule

// ===== rtl/core/sdp_dpath.sv =====
// ----------------------------------------------------------------------------
// sdp_dpath
// Accumulator, integer conversion, two scale multiplies and clamp.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"
module sdp_dpath
    import sdp_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_cmd              i_cmd,
    input  logic signed [7:0] i_act_value,
    input  logic [7:0]        i_weight_byte,
    input  logic              i_upper_half,
    input  logic signed [8:0] i_row_offset,
    input  logic [31:0]       i_act_scale_bits,
    input  logic [31:0]       i_weight_scale_bits,
    input  logic [31:0]       i_clamp_min,
    input  logic [31:0]       i_clamp_max,
    output logic [31:0]       o_result
);
    logic [ACC_W-1:0] r_acc;
    logic [ACC_W-1:0] n_acc;
    logic [31:0]      r_asc;
    logic [31:0]      r_wsc;
    logic [31:0]      r_fval;
    logic [31:0]      n_fval;
    logic [31:0]      r_res;
    logic [31:0]      n_res;
    logic [31:0]      w_mul_a;
    logic [31:0]      w_mul_b;
    logic [31:0]      w_mul_p;

    always_comb begin
        logic [3:0]         code;
        logic signed [4:0]  w;
        logic signed [9:0]  a;
        logic signed [14:0] p;
        code = i_upper_half ? i_weight_byte[7:4] : 4'(i_weight_byte & NIB_MASK);
        w = $signed({1'b0, code}) - $signed({1'b0, W_BIAS});
        a = 10'(i_act_value) + 10'(i_row_offset);
        p = 15'(a * w);
        n_acc = r_acc + ACC_W'(p);
    end

    always_comb begin
        logic             s;
        logic [ACC_W-1:0] mag;
        logic [5:0]       pos;
        logic [ACC_W-1:0] nm;
        logic [24:0]      kp;
        logic             g;
        logic             st;
        logic [7:0]       ex;
        s = r_acc[ACC_W-1];
        mag = s ? (~r_acc + 1'b1) : r_acc;
        pos = 6'd0;
        for (int k = 0; k < ACC_W; k++) begin
            if (mag[k]) begin
                pos = 6'(k);
            end
        end
        nm = mag << (6'(ACC_W - 1) - pos);
        if (ACC_W > 24) begin
            kp = {1'b0, nm[ACC_W-1 -: 24]};
            g = nm[ACC_W-25];
            st = (ACC_W > 25) ? ((nm << 25) != '0) : 1'b0;
        end else begin
            kp = {1'b0, nm[ACC_W-1 -: 24]};
            g = 1'b0;
            st = 1'b0;
        end
        kp = kp + {24'd0, (g && (st || kp[0]))};
        ex = 8'(pos) + 8'd127;
        if (kp[24]) begin
            kp = kp >> 1;
            ex = ex + 8'd1;
        end
        n_fval = (mag == '0) ? 32'd0 : {s, ex, kp[22:0]};
    end

    assign w_mul_a = i_cmd.mul2 ? w_mul_p : r_fval;
    assign w_mul_b = i_cmd.mul1 ? r_wsc : r_asc;

    sdp_fmul u_fmul (
        .i_clk (i_clk),
        .i_en  (i_cmd.mul1 || i_cmd.mul2),
        .i_a   (w_mul_a),
        .i_b   (w_mul_b),
        .o_p   (w_mul_p)
    );

    always_comb begin
        n_res = w_mul_p;
        if (f_lt(n_res, i_clamp_min)) begin
            n_res = i_clamp_min;
        end
        if (f_lt(i_clamp_max, n_res)) begin
            n_res = i_clamp_max;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc <= '0;
        end else if (i_cmd.clr) begin
            r_acc <= '0;
        end else if (i_cmd.mac) begin
            r_acc <= n_acc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.mac) begin
            r_asc <= i_act_scale_bits;
            r_wsc <= i_weight_scale_bits;
        end
        if (i_cmd.conv) begin
            r_fval <= n_fval;
        end else if (i_cmd.mul2) begin
            r_fval <= w_mul_p;
        end
        if (i_cmd.clamp) begin
            r_res <= n_res;
        end
    end

    assign o_result = r_res;

    `ASSERT_NEXT(a_clr_zero, i_clk, i_rst_n, i_cmd.clr && !i_cmd.mac, r_acc == '0)
    `ASSERT_IMPL(a_one_op, i_clk, i_rst_n, 1'b1,
        $onehot0({i_cmd.mac, i_cmd.conv, i_cmd.mul1, i_cmd.mul2, i_cmd.clamp}))
    `ASSERT_NEXT(a_mac_adds, i_clk, i_rst_n, i_cmd.mac && !i_cmd.clr,
        r_acc == $past(n_acc))
endmodule

// ===== rtl/core/sdp_ctrl.sv =====
// ----------------------------------------------------------------------------
// sdp_ctrl
// Sequencer: accumulate items, then convert, scale, clamp and deliver.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"
module sdp_ctrl
    import sdp_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    input  logic i_run_end,
    input  logic i_out_ready,
    output logic o_in_ready,
    output logic o_out_valid,
    output t_cmd o_cmd
);
    t_state r_state;
    t_state n_state;
    logic   w_acc;

    assign o_in_ready = (r_state == ST_ACC);
    assign o_out_valid = (r_state == ST_OUT);
    assign w_acc = i_in_valid && o_in_ready;

    always_comb begin
        n_state = r_state;
        o_cmd = '0;
        case (r_state)
            ST_ACC: begin
                o_cmd.mac = w_acc;
                if (w_acc && i_run_end) begin
                    n_state = ST_CONV;
                end
            end
            ST_CONV: begin
                o_cmd.conv = 1'b1;
                o_cmd.clr = 1'b1;
                n_state = ST_MUL1;
            end
            ST_MUL1: begin
                o_cmd.mul1 = 1'b1;
                n_state = ST_MUL2;
            end
            ST_MUL2: begin
                o_cmd.mul2 = 1'b1;
                n_state = ST_CLMP;
            end
            ST_CLMP: begin
                o_cmd.clamp = 1'b1;
                n_state = ST_OUT;
            end
            ST_OUT: begin
                if (i_out_ready) begin
                    n_state = ST_ACC;
                end
            end
            default: n_state = ST_ACC;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_ACC;
        end else begin
            r_state <= n_state;
        end
    end

    `ASSERT_NEXT(a_end_conv, i_clk, i_rst_n, w_acc && i_run_end, r_state == ST_CONV)
    `ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && !i_out_ready, o_out_valid)
    `ASSERT_IMPL(a_onehot, i_clk, i_rst_n, 1'b1, $onehot(r_state))
endmodule

// ===== rtl/core/int8_int4_scaled_dot_product_core.sv =====
// ----------------------------------------------------------------------------
// int8_int4_scaled_dot_product_core
// int8 by int4 dot product with binary32 scaling and clamping.
// ----------------------------------------------------------------------------
// Items that do not end a run are taken one per cycle and summed in a 32-bit
// wrapping accumulator. The item with run_end set starts the finish (integer
// to binary32, two multiplies through one shared float multiplier, clamp),
// then the result waits for the sink; no input is taken from that item until
// the result is taken. Clamp registers reset to the largest finite magnitudes.
module int8_int4_scaled_dot_product_core
    import sdp_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    sdp_in_if.sink   in_ch,
    sdp_out_if.source out_ch,
    sdp_cfg_if.sink  cfg_ch
);
    logic [31:0] r_clamp_min;
    logic [31:0] r_clamp_max;
    t_cmd        w_cmd;

    assign cfg_ch.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clamp_min <= CLAMP_MIN_RST;
            r_clamp_max <= CLAMP_MAX_RST;
        end else if (cfg_ch.valid) begin
            case (t_reg_idx'(cfg_ch.index))
                REG_CLAMP_MIN: r_clamp_min <= cfg_ch.data;
                REG_CLAMP_MAX: r_clamp_max <= cfg_ch.data;
                default: ;
            endcase
        end
    end

    sdp_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_ch.valid),
        .i_run_end   (in_ch.run_end),
        .i_out_ready (out_ch.ready),
        .o_in_ready  (in_ch.ready),
        .o_out_valid (out_ch.valid),
        .o_cmd       (w_cmd)
    );

    sdp_dpath u_dpath (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_cmd               (w_cmd),
        .i_act_value         (in_ch.act_value),
        .i_weight_byte       (in_ch.weight_byte),
        .i_upper_half        (in_ch.upper_half),
        .i_row_offset        (in_ch.row_offset),
        .i_act_scale_bits    (in_ch.act_scale_bits),
        .i_weight_scale_bits (in_ch.weight_scale_bits),
        .i_clamp_min         (r_clamp_min),
        .i_clamp_max         (r_clamp_max),
        .o_result            (out_ch.result_bits)
    );
endmodule
